// ===== hw/rtl/aln_pkg.sv =====
// ---------------------------------------------------------------------------
// aln_pkg
// Shared constants, types and the quarter-wave sine table of the adaptive
// lattice notch filter.
// ---------------------------------------------------------------------------
package aln_pkg;

  // Widths of the stream fields
  localparam int SAMPLE_BITS      = 16;
  localparam int PHASE_BITS       = 24;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + PHASE_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_BW_SINE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BW_COSINE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] BW_SINE_RST   = 16'd19261;
  localparam logic [CFG_DATA_BITS-1:0] BW_COSINE_RST = 16'd26510;
  localparam logic [CFG_DATA_BITS-1:0] STEP_SIZE_RST = 16'd2818;

  // Fixed-point formats
  localparam int COEF_BITS = 16;            // Q1.15 sines and cosines
  localparam int COEF_FRAC = 15;
  localparam int STEP_BITS = 16;            // Q0.16
  localparam int STEP_FRAC = 16;
  localparam int ST_BITS   = 24;            // Q4.20 lattice states
  localparam int ST_FRAC   = 20;
  localparam int X_BITS    = ST_FRAC + 2;   // sample in Q.20, after rounding
  localparam int O_BITS    = ST_BITS + 1;   // sample + temp2
  localparam int P_BITS    = 29;            // angle update before scaling

  // Sample <-> Q.20 conversion shifts
  localparam int XL = (SAMPLE_BITS - 1 <= ST_FRAC) ? ST_FRAC - (SAMPLE_BITS - 1) : 0;
  localparam int XR = (SAMPLE_BITS - 1 <= ST_FRAC) ? 0 : (SAMPLE_BITS - 1) - ST_FRAC;

  // Phase scaling: Q32 of 1/(2*pi), then shift down to the phase word
  localparam int INV_TWO_PI_Q32 = 683565276;
  localparam int HALF_PI_Q28    = 421657428;
  localparam int PHASE_SHIFT    = 52 - PHASE_BITS;

  // Shared multiplier and accumulator
  localparam int A_BITS    = 30;
  localparam int B_BITS    = 31;
  localparam int PROD_BITS = A_BITS + B_BITS;
  localparam int ACC_BITS  = PROD_BITS + 1;

  // Sine table addressing
  localparam int TBL_LOG   = $clog2(SINE_TABLE_DEPTH);
  localparam int QIDX_BITS = TBL_LOG + 2;
  localparam int ROM_AW    = TBL_LOG + 1;
  localparam int IDX_SHIFT = PHASE_BITS - QIDX_BITS;

  // Multiplier operand selects
  localparam logic [2:0] ASEL_X  = 3'd0;
  localparam logic [2:0] ASEL_LS = 3'd1;
  localparam logic [2:0] ASEL_O  = 3'd2;
  localparam logic [2:0] ASEL_P  = 3'd3;
  localparam logic [2:0] ASEL_T1 = 3'd4;
  localparam logic [2:0] ASEL_LF = 3'd5;

  localparam logic [2:0] BSEL_C2   = 3'd0;
  localparam logic [2:0] BSEL_S2   = 3'd1;
  localparam logic [2:0] BSEL_LF   = 3'd2;
  localparam logic [2:0] BSEL_STEP = 3'd3;
  localparam logic [2:0] BSEL_INV  = 3'd4;
  localparam logic [2:0] BSEL_SN   = 3'd5;
  localparam logic [2:0] BSEL_CS   = 3'd6;

  // Accumulator operations
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       ld_x;
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [1:0] acc_op;
    logic       ld_t1;
    logic       ld_t2;
    logic       ld_o;
    logic       ld_p1;
    logic       ld_p2;
    logic       ld_theta;
    logic       rom_cos;
    logic       ld_sn;
    logic       ld_cs;
    logic       ld_ns;
    logic       ld_lat;
    logic       ld_out;
  } aln_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } aln_status_t;

  typedef logic [COEF_BITS-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine, Taylor series in Q28, rounded to Q1.15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (64'(k) * 64'(HALF_PI_Q28) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x + (64'd1 << 27)) >> 28;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2 + (64'd1 << 27)) >> 28) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      v = (sum + 64'sd4096) >>> 13;
      if (v < 0) begin
        v = 0;
      end
      if (v > 32767) begin
        v = 32767;
      end
      rom[k] = COEF_BITS'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Round a Q.35 sum down to Q.20 and clamp to the lattice width
  function automatic logic signed [ST_BITS-1:0] rnd_sat_st(
    input logic signed [ACC_BITS-1:0] a
  );
    logic signed [ACC_BITS:0] r;
    logic [ACC_BITS-ST_BITS+1:0] hi;
    r = ($signed({a[ACC_BITS-1], a}) + $signed((ACC_BITS + 1)'(64'd1 << (COEF_FRAC - 1))))
        >>> COEF_FRAC;
    hi = r[ACC_BITS:ST_BITS-1];
    if ((&hi) || !(|hi)) begin
      return r[ST_BITS-1:0];
    end else if (r[ACC_BITS]) begin
      return {1'b1, {(ST_BITS - 1){1'b0}}};
    end else begin
      return {1'b0, {(ST_BITS - 1){1'b1}}};
    end
  endfunction

endpackage

// ===== hw/rtl/aln_ctrl.sv =====
// ---------------------------------------------------------------------------
// aln_ctrl
// Sequencer of the notch filter: steps one sample through the bandwidth
// rotation, angle update, table fetch and lattice rotation.
// ---------------------------------------------------------------------------
module aln_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  aln_pkg::aln_status_t status,
  output aln_pkg::aln_cmd_t    cmd
);
  import aln_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_BW_0  = 5'd1;
  localparam logic [4:0] ST_BW_1  = 5'd2;
  localparam logic [4:0] ST_BW_2  = 5'd3;
  localparam logic [4:0] ST_BW_3  = 5'd4;
  localparam logic [4:0] ST_BW_4  = 5'd5;
  localparam logic [4:0] ST_BW_5  = 5'd6;
  localparam logic [4:0] ST_BW_6  = 5'd7;
  localparam logic [4:0] ST_ADP_0 = 5'd8;
  localparam logic [4:0] ST_ADP_1 = 5'd9;
  localparam logic [4:0] ST_ADP_2 = 5'd10;
  localparam logic [4:0] ST_ADP_3 = 5'd11;
  localparam logic [4:0] ST_ADP_4 = 5'd12;
  localparam logic [4:0] ST_ADP_5 = 5'd13;
  localparam logic [4:0] ST_TBL_0 = 5'd14;
  localparam logic [4:0] ST_TBL_1 = 5'd15;
  localparam logic [4:0] ST_TBL_2 = 5'd16;
  localparam logic [4:0] ST_ROT_0 = 5'd17;
  localparam logic [4:0] ST_ROT_1 = 5'd18;
  localparam logic [4:0] ST_ROT_2 = 5'd19;
  localparam logic [4:0] ST_ROT_3 = 5'd20;
  localparam logic [4:0] ST_ROT_4 = 5'd21;
  localparam logic [4:0] ST_ROT_5 = 5'd22;
  localparam logic [4:0] ST_OUT   = 5'd23;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Command decode and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_x  = 1'b1;
          state_nxt = ST_BW_0;
        end
      end
      // temp1 = c2*x - s2*ls ; temp2 = s2*x + c2*ls
      ST_BW_0: begin
        cmd.a_sel = ASEL_X;  cmd.b_sel = BSEL_C2;
        state_nxt = ST_BW_1;
      end
      ST_BW_1: begin
        cmd.acc_op = ACC_LOAD;
        cmd.a_sel = ASEL_LS; cmd.b_sel = BSEL_S2;
        state_nxt = ST_BW_2;
      end
      ST_BW_2: begin
        cmd.acc_op = ACC_SUB;
        cmd.a_sel = ASEL_X;  cmd.b_sel = BSEL_S2;
        state_nxt = ST_BW_3;
      end
      ST_BW_3: begin
        cmd.ld_t1  = 1'b1;
        cmd.acc_op = ACC_LOAD;
        cmd.a_sel = ASEL_LS; cmd.b_sel = BSEL_C2;
        state_nxt = ST_BW_4;
      end
      ST_BW_4: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_BW_5;
      end
      ST_BW_5: begin
        cmd.ld_t2 = 1'b1;
        state_nxt = ST_BW_6;
      end
      ST_BW_6: begin
        cmd.ld_o  = 1'b1;
        state_nxt = ST_ADP_0;
      end
      // Angle update: o*lf, times step, times 1/(2*pi)
      ST_ADP_0: begin
        cmd.a_sel = ASEL_O;  cmd.b_sel = BSEL_LF;
        state_nxt = ST_ADP_1;
      end
      ST_ADP_1: begin
        cmd.ld_p1 = 1'b1;
        state_nxt = ST_ADP_2;
      end
      ST_ADP_2: begin
        cmd.a_sel = ASEL_P;  cmd.b_sel = BSEL_STEP;
        state_nxt = ST_ADP_3;
      end
      ST_ADP_3: begin
        cmd.ld_p2 = 1'b1;
        state_nxt = ST_ADP_4;
      end
      ST_ADP_4: begin
        cmd.a_sel = ASEL_P;  cmd.b_sel = BSEL_INV;
        state_nxt = ST_ADP_5;
      end
      ST_ADP_5: begin
        cmd.ld_theta = 1'b1;
        state_nxt    = ST_TBL_0;
      end
      // Table reads: sine first, then cosine
      ST_TBL_0: begin
        state_nxt = ST_TBL_1;
      end
      ST_TBL_1: begin
        cmd.ld_sn   = 1'b1;
        cmd.rom_cos = 1'b1;
        state_nxt   = ST_TBL_2;
      end
      ST_TBL_2: begin
        cmd.ld_cs = 1'b1;
        state_nxt = ST_ROT_0;
      end
      // ls' = sn*t1 + cs*lf ; lf' = cs*t1 - sn*lf
      ST_ROT_0: begin
        cmd.a_sel = ASEL_T1; cmd.b_sel = BSEL_SN;
        state_nxt = ST_ROT_1;
      end
      ST_ROT_1: begin
        cmd.acc_op = ACC_LOAD;
        cmd.a_sel = ASEL_LF; cmd.b_sel = BSEL_CS;
        state_nxt = ST_ROT_2;
      end
      ST_ROT_2: begin
        cmd.acc_op = ACC_ADD;
        cmd.a_sel = ASEL_T1; cmd.b_sel = BSEL_CS;
        state_nxt = ST_ROT_3;
      end
      ST_ROT_3: begin
        cmd.ld_ns  = 1'b1;
        cmd.acc_op = ACC_LOAD;
        cmd.a_sel = ASEL_LF; cmd.b_sel = BSEL_SN;
        state_nxt = ST_ROT_4;
      end
      ST_ROT_4: begin
        cmd.acc_op = ACC_SUB;
        state_nxt  = ST_ROT_5;
      end
      ST_ROT_5: begin
        cmd.ld_lat = 1'b1;
        state_nxt  = ST_OUT;
      end
      // Hand the result over once the output register is free
      ST_OUT: begin
        if (status.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/aln_datapath.sv =====
// ---------------------------------------------------------------------------
// aln_datapath
// Registers, shared multiplier and accumulator, sine table and output
// register of the notch filter; configuration registers live here too.
// ---------------------------------------------------------------------------
module aln_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [aln_pkg::IN_TDATA_BITS-1:0]     in_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [aln_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [aln_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [aln_pkg::OUT_TDATA_BITS-1:0]    out_tdata,
  input  aln_pkg::aln_cmd_t                     cmd,
  output aln_pkg::aln_status_t                  status
);
  import aln_pkg::*;

  localparam int XC_W = SAMPLE_BITS + 1 + XL;
  localparam int Y_W  = O_BITS + 1 + XR;
  localparam logic signed [XC_W-1:0] X_HALF = XC_W'((XR > 0) ? (64'd1 << (XR - 1)) : 64'd0);
  localparam logic signed [O_BITS:0] Y_HALF = (O_BITS + 1)'((XL > 0) ? (64'd1 << (XL - 1)) : 64'd0);
  localparam logic signed [PROD_BITS:0] P1_HALF = (PROD_BITS + 1)'(64'd1 << (ST_FRAC - 1));
  localparam logic signed [PROD_BITS:0] P2_HALF = (PROD_BITS + 1)'(64'd1 << (STEP_FRAC - 1));
  localparam logic signed [PROD_BITS:0] P3_HALF = (PROD_BITS + 1)'(64'd1 << (PHASE_SHIFT - 1));
  localparam logic [PHASE_BITS:0] IDX_HALF = (PHASE_BITS + 1)'(64'd1 << (IDX_SHIFT - 1));

  // Configuration
  logic signed [COEF_BITS-1:0] bw_sin_r;
  logic signed [COEF_BITS-1:0] bw_cos_r;
  logic [STEP_BITS-1:0]        step_r;

  // Filter state and per-sample working registers
  logic signed [ST_BITS-1:0]   lat_first_r;
  logic signed [ST_BITS-1:0]   lat_second_r;
  logic [PHASE_BITS-1:0]       theta_r;
  logic signed [X_BITS-1:0]    x_r;
  logic signed [ST_BITS-1:0]   t1_r;
  logic signed [ST_BITS-1:0]   t2_r;
  logic signed [O_BITS-1:0]    o_r;
  logic signed [P_BITS-1:0]    p_r;
  logic signed [COEF_BITS-1:0] sn_r;
  logic signed [COEF_BITS-1:0] cs_r;
  logic signed [ST_BITS-1:0]   ns_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [ACC_BITS-1:0]  acc_r;
  logic [COEF_BITS-1:0]        rom_q_r;
  logic                        rom_neg_r;
  logic                        out_valid_r;
  logic [OUT_TDATA_BITS-1:0]   out_data_r;

  logic signed [XC_W-1:0]      x_conv;
  logic signed [A_BITS-1:0]    mul_a;
  logic signed [B_BITS-1:0]    mul_b;
  logic signed [PROD_BITS:0]   prod_ext;
  logic signed [PROD_BITS:0]   p1_sh;
  logic signed [PROD_BITS:0]   p2_sh;
  logic signed [PROD_BITS:0]   p3_sh;
  logic [PHASE_BITS:0]         idx_sum;
  logic [QIDX_BITS-1:0]        idx;
  logic [1:0]                  quad;
  logic [TBL_LOG-1:0]          rem;
  logic [ROM_AW-1:0]           rom_addr;
  logic signed [COEF_BITS-1:0] rom_val;
  logic signed [Y_W-1:0]       y_w;
  logic [SAMPLE_BITS-1:0]      y_sat;
  logic [Y_W-SAMPLE_BITS:0]    y_hi;

  assign cfg_ready       = 1'b1;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign status.out_free = !out_valid_r || out_tready;

  // Sample to Q.20
  always_comb begin
    x_conv = ((XC_W'($signed(in_tdata[SAMPLE_BITS-1:0])) <<< XL) + X_HALF) >>> XR;
  end

  // Operand selection for the shared multiplier
  always_comb begin
    case (cmd.a_sel)
      ASEL_X:  mul_a = A_BITS'(x_r);
      ASEL_LS: mul_a = A_BITS'(lat_second_r);
      ASEL_O:  mul_a = A_BITS'(o_r);
      ASEL_P:  mul_a = A_BITS'(p_r);
      ASEL_T1: mul_a = A_BITS'(t1_r);
      ASEL_LF: mul_a = A_BITS'(lat_first_r);
      default: mul_a = '0;
    endcase
    case (cmd.b_sel)
      BSEL_C2:   mul_b = B_BITS'(bw_cos_r);
      BSEL_S2:   mul_b = B_BITS'(bw_sin_r);
      BSEL_LF:   mul_b = B_BITS'(lat_first_r);
      BSEL_STEP: mul_b = $signed(B_BITS'(step_r));
      BSEL_INV:  mul_b = B_BITS'(INV_TWO_PI_Q32);
      BSEL_SN:   mul_b = B_BITS'(sn_r);
      BSEL_CS:   mul_b = B_BITS'(cs_r);
      default:   mul_b = '0;
    endcase
  end

  // Rounded shifts of the product for the angle update chain
  assign prod_ext = {prod_r[PROD_BITS-1], prod_r};
  assign p1_sh    = (prod_ext + P1_HALF) >>> ST_FRAC;
  assign p2_sh    = (prod_ext + P2_HALF) >>> STEP_FRAC;
  assign p3_sh    = (prod_ext + P3_HALF) >>> PHASE_SHIFT;

  // Table index: phase rounded to the nearest table step, folded by quadrant
  always_comb begin
    idx_sum  = {1'b0, theta_r} + IDX_HALF;
    idx      = idx_sum[PHASE_BITS-1:IDX_SHIFT];
    quad     = idx[QIDX_BITS-1:TBL_LOG] + {1'b0, cmd.rom_cos};
    rem      = idx[TBL_LOG-1:0];
    rom_addr = quad[0] ? (ROM_AW'(SINE_TABLE_DEPTH) - {1'b0, rem}) : {1'b0, rem};
    rom_val  = rom_neg_r ? -$signed(rom_q_r) : $signed(rom_q_r);
  end

  // Notch output back to the sample format, saturated
  always_comb begin
    y_w  = Y_W'((($signed({o_r[O_BITS-1], o_r}) + Y_HALF) >>> XL)) <<< XR;
    y_hi = y_w[Y_W-1:SAMPLE_BITS-1];
    if ((&y_hi) || !(|y_hi)) begin
      y_sat = y_w[SAMPLE_BITS-1:0];
    end else if (y_w[Y_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

  // Control state: configuration, filter state, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_sin_r     <= BW_SINE_RST;
      bw_cos_r     <= BW_COSINE_RST;
      step_r       <= STEP_SIZE_RST;
      lat_first_r  <= '0;
      lat_second_r <= '0;
      theta_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BW_SINE:   bw_sin_r <= cfg_data;
          REG_BW_COSINE: bw_cos_r <= cfg_data;
          REG_STEP_SIZE: step_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.ld_theta) begin
        theta_r <= theta_r - p3_sh[PHASE_BITS-1:0];
      end
      if (cmd.ld_lat) begin
        lat_first_r  <= rnd_sat_st(acc_r);
        lat_second_r <= ns_r;
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r    <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    rom_q_r   <= SINE_ROM[rom_addr];
    rom_neg_r <= quad[1];
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= ACC_BITS'(prod_r);
      ACC_ADD:  acc_r <= acc_r + ACC_BITS'(prod_r);
      ACC_SUB:  acc_r <= acc_r - ACC_BITS'(prod_r);
      default:  acc_r <= acc_r;
    endcase
    if (cmd.ld_x) begin
      x_r <= x_conv[X_BITS-1:0];
    end
    if (cmd.ld_t1) begin
      t1_r <= rnd_sat_st(acc_r);
    end
    if (cmd.ld_t2) begin
      t2_r <= rnd_sat_st(acc_r);
    end
    if (cmd.ld_o) begin
      o_r <= O_BITS'(x_r) + O_BITS'(t2_r);
    end
    if (cmd.ld_p1) begin
      p_r <= p1_sh[P_BITS-1:0];
    end else if (cmd.ld_p2) begin
      p_r <= p2_sh[P_BITS-1:0];
    end
    if (cmd.ld_sn) begin
      sn_r <= rom_val;
    end
    if (cmd.ld_cs) begin
      cs_r <= rom_val;
    end
    if (cmd.ld_ns) begin
      ns_r <= rnd_sat_st(acc_r);
    end
    if (cmd.ld_out) begin
      out_data_r <= OUT_TDATA_BITS'({theta_r, y_sat});
    end
  end

endmodule

// ===== hw/rtl/adaptive_lattice_notch.sv =====
// ---------------------------------------------------------------------------
// adaptive_lattice_notch
// Adaptive two-stage lattice notch filter, one sample per beat.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one signed sample per beat on in_tdata.
//   out_*  : one result per input beat: notch output and the notch angle.
//   cfg_*  : register writes (0 bandwidth sine, 1 bandwidth cosine,
//            2 step size); always ready, write only while the filter is idle.
// One shared 30x31 multiplier and a single sine table read port carry all
// the work, one step after another. out_tvalid rises and in_tready returns
// in the same cycle, and only then does the filter take the next sample.
// The result waits in an output register; if the receiver stalls, the next
// sample is still taken and processed, and only its hand-over waits until
// the register frees up.
// Reset (rst_n low at a clock edge) clears lattice states and angle, loads
// the default bandwidth and step size and drops out_tvalid.
// The sine table is a constant built at elaboration; no start-up sweep.
// ---------------------------------------------------------------------------
module adaptive_lattice_notch (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [aln_pkg::IN_TDATA_BITS-1:0]     in_tdata,   // [15:0] sample_in
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [aln_pkg::OUT_TDATA_BITS-1:0]    out_tdata,  // [15:0] notch_out,
                                                            // [39:16] notch_phase
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [aln_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [aln_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import aln_pkg::*;

  aln_cmd_t    cmd;
  aln_status_t status;

  // Sequencer
  aln_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and storage
  aln_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// ===== hw/rtl/aln_checker.sv =====
// ---------------------------------------------------------------------------
// aln_checker
// Port-level checks of the notch filter, bound to the top level.
// ---------------------------------------------------------------------------
module aln_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  input  logic                                  in_tready,
  input  logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic [aln_pkg::OUT_TDATA_BITS-1:0]    out_tdata
);
  import aln_pkg::*;

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending and the input side ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the filter");

  // One sample at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken while busy");

  // No result can appear in the cycle after a sample is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

endmodule

bind adaptive_lattice_notch aln_checker u_aln_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
